@@ hw/rtl/ssrch_pkg.sv @@
package ssrch_pkg;

    typedef logic [7:0] t_char;

    localparam t_char STOP_CHAR = 8'h3B;
    localparam t_char NUL_CHAR  = 8'h00;

    localparam int KEY_REG_W = 64;
    localparam int LEN_REG_W = 4;
    localparam int CFG_IDX_W = 1;
    localparam int START_W   = 7;
    localparam int COL_OUT_W = 7;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_KEY_BYTES  = 1'b0;
    localparam t_cfg_idx REG_KEY_LENGTH = 1'b1;

endpackage

@@ hw/rtl/substring_search_with_stop_char_core.sv @@
// A result beat passes from the input register, which takes the last beat of a card, to the
// result register, which drives the master side (one input register, one result register).
// Throughput: one beat per cycle; a last beat waits in the input register while the
// previous result is still held on the master side, other beats drain past it.
// Reset (i_rst_n low at a rising edge) empties both registers, clears the key
// registers and returns the card state to an empty card searched from column 0.
module substring_search_with_stop_char_core
    import ssrch_pkg::*;
#(
    parameter int KEY_MAX  = 8,
    parameter int CARD_LEN = 128
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_cfg_we,
    input  t_cfg_idx             i_cfg_addr,
    input  logic [KEY_REG_W-1:0] i_cfg_data,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // Bits 7:0 card_byte, bits 14:8 search_start, bit 15 zero.
    input  logic [15:0]          s_axis_tdata,
    // Bit 0 first_of_card.
    input  logic                 s_axis_tuser,
    input  logic                 s_axis_tlast,

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // Bit 0 key_found, bits 7:1 match_column.
    output logic [7:0]           m_axis_tdata
);

    localparam int CW    = $clog2(CARD_LEN + 1);
    localparam int XW    = CW + START_W;
    localparam int WIN_W = 8 * KEY_MAX;
    localparam logic [CW-1:0] CARD_END = CW'(CARD_LEN);
    localparam logic [LEN_REG_W-1:0] LEN_MAX = LEN_REG_W'(KEY_MAX);

    logic [KEY_REG_W-1:0] r_key;
    logic [LEN_REG_W-1:0] r_key_len;

    logic               r_in_valid;
    t_char              r_in_byte;
    logic [START_W-1:0] r_in_start;
    logic               r_in_first;
    logic               r_in_last;

    logic [WIN_W-1:0]   r_win,   n_win;
    logic [CW-1:0]      r_count, n_count;
    logic [START_W-1:0] r_start, n_start;
    logic [CW-1:0]      r_stop,  n_stop;
    logic               r_ended, n_ended;
    logic               r_seen,  n_seen;
    logic [CW-1:0]      r_pos,   n_pos;

    logic                 r_out_valid;
    logic                 r_out_found, n_out_found;
    logic [COL_OUT_W-1:0] r_out_col,   n_out_col;

    logic [LEN_REG_W-1:0] used_len;
    logic                 s1_go;
    logic                 in_accept;

    assign used_len      = (r_key_len > LEN_MAX) ? LEN_MAX : r_key_len;
    assign s1_go         = r_in_valid && (!r_in_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || s1_go;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_col, r_out_found};

    always_comb begin
        logic [CW-1:0]        c;
        logic [CW-1:0]        c_inc;
        logic [CW-1:0]        p;
        logic [CW-1:0]        eff;
        logic                 hit;
        logic [LEN_REG_W-1:0] kdiff;
        logic [XW-1:0]        col_x;

        n_win   = r_win;
        n_count = r_count;
        n_start = r_start;
        n_stop  = r_stop;
        n_ended = r_ended;
        n_seen  = r_seen;
        n_pos   = r_pos;

        if (r_in_first) begin
            n_win   = '0;
            n_count = '0;
            n_start = r_in_start;
            n_stop  = CARD_END;
            n_ended = 1'b0;
            n_seen  = 1'b0;
            n_pos   = '0;
        end

        c     = n_count;
        c_inc = c + CW'(1);
        p     = c_inc - CW'(used_len);
        hit   = 1'b1;
        kdiff = '0;

        if (!n_ended && c < CARD_END) begin
            if (r_in_byte == NUL_CHAR) begin
                n_ended = 1'b1;
            end else begin
                n_win = WIN_W'({n_win, r_in_byte});
                if (r_in_byte == STOP_CHAR && XW'(c) >= XW'(n_start) && c < n_stop) begin
                    n_stop = c;
                end
                for (int i = 0; i < KEY_MAX; i++) begin
                    kdiff = used_len - LEN_REG_W'(i) - LEN_REG_W'(1);
                    if (LEN_REG_W'(i) < used_len &&
                        n_win[8*i +: 8] != r_key[8*kdiff[2:0] +: 8]) begin
                        hit = 1'b0;
                    end
                end
                if (!n_seen && used_len != '0 && c_inc >= CW'(used_len) &&
                    XW'(p) >= XW'(n_start) && p < n_stop && hit) begin
                    n_seen = 1'b1;
                    n_pos  = p;
                end
                n_count = c_inc;
            end
        end

        if (r_in_last) begin
            n_ended = 1'b1;
        end

        eff         = (n_count < n_stop) ? n_count : n_stop;
        n_out_found = 1'b0;
        col_x       = '0;
        if (n_seen) begin
            n_out_found = 1'b1;
            col_x       = XW'(n_pos);
        end else if (used_len == '0 && XW'(n_start) < XW'(eff)) begin
            n_out_found = 1'b1;
            col_x       = XW'(n_start);
        end
        n_out_col = col_x[COL_OUT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key     <= '0;
            r_key_len <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_KEY_BYTES:  r_key     <= i_cfg_data;
                REG_KEY_LENGTH: r_key_len <= i_cfg_data[LEN_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (s1_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte  <= s_axis_tdata[7:0];
            r_in_start <= s_axis_tdata[14:8];
            r_in_first <= s_axis_tuser;
            r_in_last  <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win   <= '0;
            r_count <= '0;
            r_start <= '0;
            r_stop  <= CARD_END;
            r_ended <= 1'b0;
            r_seen  <= 1'b0;
            r_pos   <= '0;
        end else if (s1_go) begin
            r_win   <= n_win;
            r_count <= n_count;
            r_start <= n_start;
            r_stop  <= n_stop;
            r_ended <= n_ended;
            r_seen  <= n_seen;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_in_last) begin
            r_out_found <= n_out_found;
            r_out_col   <= n_out_col;
        end
    end

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && r_in_last) |=> r_out_valid)
        else $error("last beat of a card did not load a result");

    a_match_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen |-> (XW'(r_pos) >= XW'(r_start) && r_pos < r_stop))
        else $error("recorded match lies outside the search range");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CARD_END && r_stop <= CARD_END)
        else $error("column count or stop column beyond card length");

    a_col_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> (r_out_col == '0))
        else $error("match column not zero on a result without a match");

endmodule
